/* rtl/bsc_pkg.sv */
// Shared types, codes and helpers for the banker's safety check block.
package bsc_pkg;

  // Default sizing of the block.
  localparam int unsigned PROCESSES_DEF   = 8;
  localparam int unsigned RESOURCES_DEF   = 4;
  localparam int unsigned COUNT_WIDTH_DEF = 8;

  // A run checks at most this many process rows and emits at most this many words.
  localparam int unsigned SEQ_MAX = 8;
  localparam int unsigned SEQ_IW  = 3;

  // Port widths.
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PROCESSES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_RESOURCES = 2'd1;

  // Input word kinds carried on tuser.
  typedef enum logic [IN_USER_W-1:0] {
    CMD_LOAD_PROC  = 2'd0,
    CMD_LOAD_AVAIL = 2'd1,
    CMD_RUN        = 2'd2
  } cmd_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_EMIT,
    ST_UNSAFE
  } state_e;

  // Result of a lowest-set-bit search.
  typedef struct packed {
    logic              hit;
    logic [SEQ_IW-1:0] idx;
  } pick_t;

  // Lowest set bit of a process mask.
  function automatic pick_t first_set(input logic [SEQ_MAX-1:0] m);
    pick_t pick;
    pick.hit = 1'b0;
    pick.idx = '0;
    for (int i = SEQ_MAX - 1; i >= 0; i--) begin
      if (m[i]) begin
        pick.hit = 1'b1;
        pick.idx = SEQ_IW'(i);
      end
    end
    return pick;
  endfunction

endpackage

/* rtl/bsc_claim_ram.sv */
// Claim memory holding each process's maximum and allocation per resource.
module bsc_claim_ram #(
  parameter int unsigned AW = 5,
  parameter int unsigned CW = bsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [CW-1:0] wmax_i,
  input  logic [CW-1:0] walloc_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [CW-1:0] rmax_o,
  output logic [CW-1:0] ralloc_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [2*CW-1:0]  mem_q [DEPTH];
  logic [2*CW-1:0]  rdata_q;
  logic [DEPTH-1:0] vld_q;
  logic             rvld_q;

  // Storage array with a registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {walloc_i, wmax_i};
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // Per-entry written flags, so that entries never loaded read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rmax_o   = rvld_q ? rdata_q[CW-1:0]    : '0;
  assign ralloc_o = rvld_q ? rdata_q[2*CW-1:CW] : '0;

endmodule

/* rtl/bankers_safety_check_core.sv */
// Banker's algorithm safety check: claim tables, run controller and result output.
// A load word (process entry or available count) is stored while idle. A run word starts a
// scan that reads the claim memory one resource per cycle for each unfinished process row
// visited, the compare running in the cycle after the memory read, and a finished row's
// allocation is added to the work vector in the cycle of its last compare. Passes repeat
// over the unfinished rows; then the result words go out (np words when safe, one when
// unsafe), one per cycle while the output is not stalled, where np is the active process
// count. Input words are refused while a run is in progress; the last result word may still
// wait at the output while the next input word is taken. The claim memory needs no clearing
// pass after reset.
module bankers_safety_check_core #(
  parameter int unsigned PROCESSES   = bsc_pkg::PROCESSES_DEF,
  parameter int unsigned RESOURCES   = bsc_pkg::RESOURCES_DEF,
  parameter int unsigned COUNT_WIDTH = bsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  // proc_index [2:0], res_index [4:3], max_value [12:5], alloc_value [20:13],
  // avail_value [28:21], zero fill [31:29]
  input  logic [bsc_pkg::IN_DATA_W-1:0]  s_tdata_i,
  // cmd [1:0]
  input  logic [bsc_pkg::IN_USER_W-1:0]  s_tuser_i,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  // safe [0], seq_process [3:1], seq_position [6:4], zero fill [7]
  output logic [bsc_pkg::OUT_DATA_W-1:0] m_tdata_o,
  // last
  output logic                           m_tlast_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import bsc_pkg::*;

  localparam int unsigned PW   = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int unsigned RW   = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned WW   = COUNT_WIDTH + $clog2(PROCESSES + 1);
  localparam int unsigned CCW  = $clog2(RESOURCES + 1);
  localparam int unsigned PMAX = (PROCESSES < SEQ_MAX) ? PROCESSES : SEQ_MAX;

  // Input word fields.
  logic [2:0] in_proc;
  logic [1:0] in_res;
  logic [7:0] in_max;
  logic [7:0] in_alloc;
  logic [7:0] in_avail;

  assign in_proc  = s_tdata_i[2:0];
  assign in_res   = s_tdata_i[4:3];
  assign in_max   = s_tdata_i[12:5];
  assign in_alloc = s_tdata_i[20:13];
  assign in_avail = s_tdata_i[28:21];

  // Registers.
  state_e            state_q, state_d;
  logic [3:0]        act_proc_q;
  logic [2:0]        act_res_q;
  logic [3:0]        np_q, np_d;
  logic [3:0]        nr_q, nr_d;
  logic [SEQ_IW-1:0] p_q, p_d;
  logic [CCW-1:0]    c_q, c_d;
  logic [3:0]        count_q, count_d;
  logic              found_q, found_d;
  logic [SEQ_MAX-1:0] fin_q, fin_d;
  logic [SEQ_IW-1:0] k_q, k_d;
  logic [CW-1:0]     avail_q [RESOURCES];
  logic [CW-1:0]     avail_d [RESOURCES];
  logic [WW-1:0]     work_q [RESOURCES];
  logic [WW-1:0]     work_d [RESOURCES];
  logic [CW-1:0]     rowbuf_q [RESOURCES];
  logic [CW-1:0]     rowbuf_d [RESOURCES];
  logic [SEQ_IW-1:0] seq_q [SEQ_MAX];
  logic              seq_we;
  logic              out_vld_q, out_vld_d;
  logic              out_safe_q, out_safe_d;
  logic [SEQ_IW-1:0] out_proc_q, out_proc_d;
  logic [SEQ_IW-1:0] out_pos_q, out_pos_d;
  logic              out_last_q, out_last_d;

  // Claim memory port signals.
  logic          ram_we;
  logic [PW+RW-1:0] ram_waddr;
  logic          ram_re;
  logic [PW+RW-1:0] ram_raddr;
  logic [CW-1:0] ram_max;
  logic [CW-1:0] ram_alloc;

  // Scan control.
  logic              in_acc;
  logic              out_free;
  logic              cmp_act;
  logic [RW-1:0]     cr;
  logic [WW:0]       lhs, rhs;
  logic              fits;
  logic              row_fail;
  logic              row_ok;
  logic              row_end;
  logic              found_now;
  logic [3:0]        count_new;
  logic [SEQ_MAX-1:0] fin_new;
  logic [SEQ_MAX-1:0] later_mask;
  logic [SEQ_MAX-1:0] pass_mask;
  pick_t             next_row;
  pick_t             pass_row;
  logic              emit_last;
  logic [3:0]        np_run;
  logic [3:0]        nr_run;

  assign in_acc      = s_tvalid_i && s_tready_o;
  assign s_tready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_vld_q || m_tready_i;

  // Active counts saturated to the sizes the tables support, a zero count taken as one.
  always_comb begin
    if (act_proc_q == 4'd0) begin
      np_run = 4'd1;
    end else if (act_proc_q > 4'(PMAX)) begin
      np_run = 4'(PMAX);
    end else begin
      np_run = act_proc_q;
    end
    if (act_res_q == 3'd0) begin
      nr_run = 4'd1;
    end else if ({1'b0, act_res_q} > 4'(RESOURCES)) begin
      nr_run = 4'(RESOURCES);
    end else begin
      nr_run = {1'b0, act_res_q};
    end
  end

  bsc_claim_ram #(
    .AW (PW + RW),
    .CW (CW)
  ) u_ram (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wmax_i   (CW'(in_max)),
    .walloc_i (CW'(in_alloc)),
    .re_i     (ram_re),
    .raddr_i  (ram_raddr),
    .rmax_o   (ram_max),
    .ralloc_o (ram_alloc)
  );

  // Memory access: loads write in idle, the scan reads one resource per cycle.
  assign ram_we    = in_acc && (s_tuser_i == CMD_LOAD_PROC) &&
                     (32'(in_proc) < PROCESSES) && (32'(in_res) < RESOURCES);
  assign ram_waddr = {PW'(in_proc), RW'(in_res)};
  assign ram_re    = (state_q == ST_ROW) && (4'(c_q) < nr_q);
  assign ram_raddr = {PW'(p_q), RW'(c_q)};

  // Row compare in the cycle after the read, and the choice of the next row.
  always_comb begin
    cmp_act   = (state_q == ST_ROW) && (c_q != '0);
    cr        = RW'(c_q - CCW'(1));
    lhs       = (WW+1)'(ram_max);
    rhs       = (WW+1)'(ram_alloc) + (WW+1)'(work_q[cr]);
    fits      = (lhs <= rhs);
    row_fail  = cmp_act && !fits;
    row_ok    = cmp_act && fits && (4'(c_q) == nr_q);
    row_end   = row_fail || row_ok;
    found_now = found_q || row_ok;
    count_new = count_q + {3'd0, row_ok};
    fin_new   = fin_q;
    if (row_ok) begin
      fin_new[p_q] = 1'b1;
    end
    for (int i = 0; i < SEQ_MAX; i++) begin
      later_mask[i] = !fin_new[i] && (4'(i) > {1'b0, p_q}) && (4'(i) < np_q);
      pass_mask[i]  = !fin_new[i] && (4'(i) < np_q);
    end
    next_row  = first_set(later_mask);
    pass_row  = first_set(pass_mask);
    emit_last = ({1'b0, k_q} == (np_q - 4'd1));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_tuser_i == CMD_RUN)) begin
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        if (row_end && !next_row.hit) begin
          if (!found_now) begin
            state_d = ST_UNSAFE;
          end else if (count_new == np_q) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_UNSAFE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output word updates.
  always_comb begin
    np_d       = np_q;
    nr_d       = nr_q;
    p_d        = p_q;
    c_d        = c_q;
    count_d    = count_q;
    found_d    = found_q;
    fin_d      = fin_q;
    k_d        = k_q;
    avail_d    = avail_q;
    work_d     = work_q;
    rowbuf_d   = rowbuf_q;
    seq_we     = 1'b0;
    out_vld_d  = out_vld_q && !m_tready_i;
    out_safe_d = out_safe_q;
    out_proc_d = out_proc_q;
    out_pos_d  = out_pos_q;
    out_last_d = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_tuser_i == CMD_LOAD_AVAIL) && (32'(in_res) < RESOURCES)) begin
          avail_d[RW'(in_res)] = CW'(in_avail);
        end
        if (in_acc && (s_tuser_i == CMD_RUN)) begin
          np_d    = np_run;
          nr_d    = nr_run;
          p_d     = '0;
          c_d     = '0;
          count_d = '0;
          found_d = 1'b0;
          fin_d   = '0;
          k_d     = '0;
          for (int r = 0; r < RESOURCES; r++) begin
            work_d[r] = WW'(avail_q[r]);
          end
        end
      end
      ST_ROW: begin
        if (cmp_act) begin
          rowbuf_d[cr] = ram_alloc;
        end
        // A row that fits releases its whole allocation into work.
        if (row_ok) begin
          for (int r = 0; r < RESOURCES; r++) begin
            if (4'(r) < nr_q) begin
              work_d[r] = work_q[r] + WW'((RW'(r) == cr) ? ram_alloc : rowbuf_q[r]);
            end
          end
          seq_we = 1'b1;
        end
        if (row_end) begin
          fin_d   = fin_new;
          count_d = count_new;
          c_d     = '0;
          if (next_row.hit) begin
            p_d     = next_row.idx;
            found_d = found_now;
          end else begin
            // End of a pass: start again from the lowest unfinished row.
            p_d     = pass_row.idx;
            found_d = 1'b0;
          end
        end else begin
          c_d = c_q + CCW'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_safe_d = 1'b1;
          out_proc_d = seq_q[k_q];
          out_pos_d  = k_q;
          out_last_d = emit_last;
          k_d        = k_q + SEQ_IW'(1);
        end
      end
      ST_UNSAFE: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_safe_d = 1'b0;
          out_proc_d = '0;
          out_pos_d  = '0;
          out_last_d = 1'b1;
        end
      end
      default: begin
        out_vld_d = out_vld_q;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      act_proc_q <= 4'd8;
      act_res_q  <= 3'd4;
      np_q       <= 4'd1;
      nr_q       <= 4'd1;
      p_q        <= '0;
      c_q        <= '0;
      count_q    <= '0;
      found_q    <= 1'b0;
      fin_q      <= '0;
      k_q        <= '0;
      out_vld_q  <= 1'b0;
      for (int r = 0; r < RESOURCES; r++) begin
        avail_q[r] <= '0;
        work_q[r]  <= '0;
      end
    end else begin
      state_q <= state_d;
      np_q    <= np_d;
      nr_q    <= nr_d;
      p_q     <= p_d;
      c_q     <= c_d;
      count_q <= count_d;
      found_q <= found_d;
      fin_q   <= fin_d;
      k_q     <= k_d;
      out_vld_q <= out_vld_d;
      avail_q <= avail_d;
      work_q  <= work_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_ACTIVE_PROCESSES) begin
          act_proc_q <= cfg_data_i[3:0];
        end else if (cfg_index_i == CFG_ACTIVE_RESOURCES) begin
          act_res_q <= cfg_data_i[2:0];
        end
      end
    end
  end

  // Payload registers: row buffer, safe sequence and output word.
  always_ff @(posedge clk_i) begin
    rowbuf_q   <= rowbuf_d;
    out_safe_q <= out_safe_d;
    out_proc_q <= out_proc_d;
    out_pos_q  <= out_pos_d;
    out_last_q <= out_last_d;
    if (seq_we) begin
      seq_q[count_q[SEQ_IW-1:0]] <= p_q;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {1'b0, out_pos_q, out_proc_q, out_safe_q};
  assign m_tlast_o  = out_last_q;

endmodule

/* rtl/bsc_checker.sv */
// Port-level checks for the banker's safety check block, bound to the top level.
module bsc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_tready_o,
  input logic                           m_tvalid_o,
  input logic                           m_tready_i,
  input logic [bsc_pkg::OUT_DATA_W-1:0] m_tdata_o,
  input logic                           m_tlast_o
);

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tlast_o))
    else $error("result word changed while stalled");

  // An unsafe verdict is a single word with zero process and position.
  a_unsafe_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tdata_o[0] |-> m_tlast_o && (m_tdata_o[7:1] == 7'd0))
    else $error("unsafe word malformed");

  // Sequence words follow each other with rising positions.
  a_seq_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tready_i && m_tdata_o[0] && !m_tlast_o |=>
      m_tvalid_o && m_tdata_o[0] &&
      (m_tdata_o[6:4] == 3'($past(m_tdata_o[6:4]) + 3'd1)))
    else $error("safe sequence position skipped");

  // No input word is taken while a safe sequence is still being delivered.
  a_no_input_mid_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[0] && !m_tlast_o |-> !s_tready_o)
    else $error("input taken during sequence output");

endmodule

bind bankers_safety_check_core bsc_checker u_bsc_checker (.*);

/* tb/bankers_safety_check_core_tb.sv */
// Self-checking testbench for the banker's safety check core: claim loads, runs and limits.
`timescale 1ns / 100ps

module bankers_safety_check_core_tb;
  import bsc_pkg::*;

  // Codes that the block must ignore.
  localparam logic [1:0]           CMD_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // Waiting times in clock cycles, and the overall limit in ns.
  localparam int unsigned IDLE_GUARD  = 8;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TIMEOUT_NS  = 1_000_000;

  // One sequence word as the block should present it.
  typedef struct packed {
    logic        safe;
    logic [2:0]  proc;
    logic [2:0]  pos;
    logic        last;
  } seq_word_t;

  // Scoreboard: shadow copy of the claim tables and the limits, plus the queue of
  // sequence words still owed by the block.
  class safety_scoreboard;
    logic [7:0]  claim_max   [8][4];
    logic [7:0]  claim_alloc [8][4];
    logic [7:0]  free_units  [4];
    int unsigned proc_limit;
    int unsigned res_limit;
    seq_word_t   words_due[$];
    int unsigned errors;

    function new();
      for (int p = 0; p < 8; p++) begin
        for (int r = 0; r < 4; r++) begin
          claim_max[p][r]   = '0;
          claim_alloc[p][r] = '0;
        end
      end
      for (int r = 0; r < 4; r++) free_units[r] = '0;
      proc_limit = 8;
      res_limit  = 4;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return words_due.size();
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ACTIVE_PROCESSES) begin
        proc_limit = data;
      end else if (idx == CFG_ACTIVE_RESOURCES) begin
        res_limit = data[2:0];
      end
    endfunction

    // Banker's safety check over the shadow tables; queues the words it should emit.
    function void run_safety_check();
      int unsigned np;
      int unsigned nr;
      int unsigned count;
      int unsigned p;
      int unsigned r;
      int          need;
      logic [11:0] work [4];
      logic [7:0]  done;
      logic [2:0]  order [8];
      bit          progress;
      bit          fits;
      seq_word_t   w;

      np = (proc_limit < 1) ? 1 : (proc_limit > 8) ? 8 : proc_limit;
      nr = (res_limit < 1) ? 1 : (res_limit > 4) ? 4 : res_limit;
      for (r = 0; r < 4; r++) work[r] = 12'(free_units[r]);
      done  = '0;
      count = 0;
      while (count < np) begin
        progress = 1'b0;
        for (p = 0; p < np; p++) begin
          if (!done[p]) begin
            fits = 1'b1;
            for (r = 0; r < nr; r++) begin
              need = int'(claim_max[p][r]) - int'(claim_alloc[p][r]);
              if (need > int'(work[r])) fits = 1'b0;
            end
            // A process that fits releases its allocation straight away.
            if (fits) begin
              for (r = 0; r < nr; r++) work[r] = work[r] + 12'(claim_alloc[p][r]);
              order[count] = 3'(p);
              count++;
              done[p]  = 1'b1;
              progress = 1'b1;
            end
          end
        end
        if (!progress) begin
          w = '{safe: 1'b0, proc: 3'd0, pos: 3'd0, last: 1'b1};
          words_due.push_back(w);
          return;
        end
      end
      for (int k = 0; k < np; k++) begin
        w = '{safe: 1'b1, proc: order[k], pos: 3'(k), last: (k + 1 == np)};
        words_due.push_back(w);
      end
    endfunction

    // Called for every input word the block accepts.
    function void note_word(logic [1:0] cmd, logic [IN_DATA_W-1:0] data);
      logic [2:0] pi;
      logic [1:0] ri;
      pi = data[2:0];
      ri = data[4:3];
      case (cmd)
        CMD_LOAD_PROC: begin
          claim_max[pi][ri]   = data[12:5];
          claim_alloc[pi][ri] = data[20:13];
        end
        CMD_LOAD_AVAIL: begin
          free_units[ri] = data[28:21];
        end
        CMD_RUN: begin
          run_safety_check();
        end
        default: begin
        end
      endcase
    endfunction

    // Called for every output word the block hands over.
    function void check_word(logic [OUT_DATA_W-1:0] data, logic last);
      seq_word_t want;
      if (words_due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: unexpected word data=%h last=%b", $realtime, data, last);
        end
        return;
      end
      want = words_due.pop_front();
      if (data[0] !== want.safe || data[3:1] !== want.proc || data[6:4] !== want.pos ||
          last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $write("%0t: word mismatch: expected safe=%b proc=%0d pos=%0d last=%b, ",
                 $realtime, want.safe, want.proc, want.pos, want.last);
          $display("got safe=%b proc=%0d pos=%0d last=%b",
                   data[0], data[3:1], data[6:4], last);
        end
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  s_tvalid_i  = 1'b0;
  logic                  s_tready_o;
  logic [IN_DATA_W-1:0]  s_tdata_i   = '0;
  logic [IN_USER_W-1:0]  s_tuser_i   = '0;
  logic                  m_tvalid_o;
  logic                  m_tready_i  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata_o;
  logic                  m_tlast_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  safety_scoreboard sb;
  bit          steady     = 1'b0;
  bit          hold_start = 1'b0;
  logic        rx_hold    = 1'b0;
  int unsigned phase_words;

  bankers_safety_check_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Output side: random back-pressure, none in a steady stretch, full during a hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else if (rx_hold) begin
      m_tready_i <= 1'b0;
    end else if (steady) begin
      m_tready_i <= 1'b1;
    end else begin
      m_tready_i <= ($urandom_range(0, 99) >= 30);
    end
  end

  // Every word leaving the block is checked against the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      sb.check_word(m_tdata_o, m_tlast_o);
    end
  end

  // Long hold-off on the output so that a run cannot drain and the input backs up.
  initial begin
    wait (hold_start);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("bankers_safety_check_core_tb NOT OK");
    $finish;
  end

  function automatic logic [IN_DATA_W-1:0] pack_fields(logic [2:0] p, logic [1:0] r,
                                                       logic [7:0] mx, logic [7:0] al,
                                                       logic [7:0] av);
    return {3'b000, av, al, mx, r, p};
  endfunction

  // Offer one input word, with random gaps in front unless steady, and wait until it is taken.
  task automatic send_word(input logic [1:0] cmd, input logic [IN_DATA_W-1:0] data);
    while (!steady && $urandom_range(0, 99) < 30) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= cmd;
    s_tdata_i  <= data;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    sb.note_word(cmd, data);
    if (cmd != CMD_UNUSED) phase_words++;
  endtask

  // Stop offering words and wait until the block has nothing left to say.
  task automatic settle(input int unsigned guard);
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (guard) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.note_config(idx, data);
  endtask

  // 1 to 5 loads of plausible claims or free counts, noise or runs, closed by a run.
  task automatic random_episode();
    int unsigned loads;
    int unsigned k;
    int unsigned pick;
    int          ofs;
    logic [7:0]  al;
    logic [7:0]  mx;
    logic [7:0]  av;
    logic [2:0]  p;
    logic [1:0]  r;
    loads = $urandom_range(1, 5);
    for (k = 0; k < loads; k++) begin
      pick = $urandom_range(0, 9);
      p    = 3'($urandom_range(0, 7));
      r    = 2'($urandom_range(0, 3));
      al   = 8'($urandom_range(0, 20));
      ofs  = int'($urandom_range(0, 26)) - 6;
      mx   = (int'(al) + ofs < 0) ? 8'd0 : 8'(int'(al) + ofs);
      av   = 8'($urandom_range(0, 14));
      if (pick < 5) begin
        send_word(CMD_LOAD_PROC, pack_fields(p, r, mx, al, av));
      end else if (pick < 7) begin
        send_word(CMD_LOAD_AVAIL, pack_fields(p, r, mx, al, av));
      end else if (pick == 7) begin
        // Full-range values, so every bit of the counts moves.
        send_word(2'($urandom_range(0, 1)),
                  pack_fields(p, r, 8'($urandom), 8'($urandom), 8'($urandom)));
      end else if (pick == 8) begin
        send_word(CMD_UNUSED, pack_fields(p, r, 8'($urandom), 8'($urandom), 8'($urandom)));
      end else begin
        send_word(CMD_RUN, pack_fields(p, r, mx, al, av));
      end
    end
    send_word(CMD_RUN, pack_fields(p, r, 8'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  // Set both limits, poke an unused register index, then fill the phase with episodes.
  task automatic run_phase(input logic [3:0] np_d, input logic [3:0] nr_d,
                           input int unsigned budget);
    settle(IDLE_GUARD);
    write_reg(CFG_ACTIVE_PROCESSES, np_d);
    write_reg(CFG_ACTIVE_RESOURCES, nr_d);
    write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, 4'($urandom));
    cfg_valid_i <= 1'b0;
    phase_words = 0;
    while (phase_words < budget) random_episode();
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset limits of eight processes and four resources.
    // Empty tables: every process fits, sequence in index order.
    send_word(CMD_RUN, '0);
    // One full claim with nothing free: unsafe.
    send_word(CMD_LOAD_PROC, pack_fields(3'd7, 2'd3, 8'hFF, 8'h00, 8'h00));
    send_word(CMD_RUN, '0);
    send_word(CMD_LOAD_AVAIL, pack_fields(3'd0, 2'd3, 8'h00, 8'h00, 8'hFF));
    send_word(CMD_RUN, '0);
    // Negative needs, and a need that only fits exactly.
    send_word(CMD_LOAD_PROC, pack_fields(3'd0, 2'd0, 8'h00, 8'hFF, 8'h00));
    send_word(CMD_LOAD_PROC, pack_fields(3'd2, 2'd1, 8'h55, 8'hAA, 8'h00));
    send_word(CMD_LOAD_PROC, pack_fields(3'd5, 2'd2, 8'hAA, 8'h55, 8'h00));
    send_word(CMD_RUN, '0);
    send_word(CMD_LOAD_AVAIL, pack_fields(3'd0, 2'd2, 8'h00, 8'h00, 8'h55));
    send_word(CMD_RUN, '0);
    // One unit short until a later process releases it: needs a second pass.
    send_word(CMD_LOAD_AVAIL, pack_fields(3'd0, 2'd2, 8'h00, 8'h00, 8'h54));
    send_word(CMD_LOAD_PROC, pack_fields(3'd6, 2'd2, 8'h00, 8'h01, 8'h00));
    send_word(CMD_RUN, '0);
    // Unknown command must leave everything alone.
    send_word(CMD_UNUSED, 32'h1FFF_FFFF);
    send_word(CMD_RUN, 32'h1FFF_FFFF);

    // Random phases across the range of limits, extremes and out-of-range values among them.
    run_phase(4'd1, 4'd1, 13);
    run_phase(4'd15, 4'd7, 13);
    steady = 1'b1;
    run_phase(4'd3, 4'd2, 13);
    settle(IDLE_GUARD);
    steady = 1'b0;
    hold_start = 1'b1;
    run_phase(4'd8, 4'd4, 14);
    run_phase(4'd0, 4'd12, 13);
    run_phase(4'd5, 4'd3, 13);
    run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 14);

    settle(TAIL_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("bankers_safety_check_core_tb OK");
    end else begin
      $display("bankers_safety_check_core_tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bsc_pkg.sv
rtl/bsc_claim_ram.sv
rtl/bankers_safety_check_core.sv
rtl/bsc_checker.sv
tb/bankers_safety_check_core_tb.sv
